FILE: hdl/shs_pkg.sv
`default_nettype none
package shs_pkg;
  localparam int GRID_COLS = 256;
  localparam int GRID_ROWS = 256;
  localparam int STORE_SIDE = 256;
  localparam int CORDIC_STEPS = 16;
  localparam logic signed [17:0] CORDIC_START = 18'sd19898;

  localparam logic [1:0] REG_POSE_X = 2'd0;
  localparam logic [1:0] REG_POSE_Y = 2'd1;
  localparam logic [1:0] REG_HEADING = 2'd2;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_OBS = 1'b1;

  // front to back queue entry
  typedef struct packed {
    logic is_obs;
    logic last;
    logic [7:0] col;
    logic [7:0] row;
    logic [15:0] value;
    logic [15:0] range;
    logic [15:0] angle;
  } job_t;

  function automatic logic signed [16:0] atan_unit(input logic [3:0] i);
    unique case (i)
      4'd0: atan_unit = 17'sd8192;
      4'd1: atan_unit = 17'sd4836;
      4'd2: atan_unit = 17'sd2555;
      4'd3: atan_unit = 17'sd1297;
      4'd4: atan_unit = 17'sd651;
      4'd5: atan_unit = 17'sd326;
      4'd6: atan_unit = 17'sd163;
      4'd7: atan_unit = 17'sd81;
      4'd8: atan_unit = 17'sd41;
      4'd9: atan_unit = 17'sd20;
      4'd10: atan_unit = 17'sd10;
      4'd11: atan_unit = 17'sd5;
      4'd12: atan_unit = 17'sd3;
      4'd13: atan_unit = 17'sd1;
      4'd14: atan_unit = 17'sd1;
      default: atan_unit = 17'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

FILE: hdl/shs_front.sv
`default_nettype none
module shs_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic s_tuser,
  input  wire logic s_tlast,
  input  wire logic [15:0] heading,
  output logic q_valid,
  input  wire logic q_ready,
  output shs_pkg::job_t q_job
);
  import shs_pkg::*;
  localparam int DEPTH = 4;
  job_t mem [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  job_t job_in;
  logic push, pop;

  assign s_tready = (fill != 3'(DEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (fill != 3'd0);
  assign pop = q_valid && q_ready;
  assign q_job = mem[rd_ptr];

  always_comb begin
    job_in.is_obs = s_tuser;
    job_in.last = s_tlast && s_tuser;
    job_in.col = s_tdata[7:0];
    job_in.row = s_tdata[15:8];
    job_in.value = s_tdata[31:16];
    job_in.range = s_tdata[47:32];
    // absolute beam angle, wraps at one turn
    job_in.angle = s_tdata[63:48] + heading;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= job_in;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/shs_back.sv
`default_nettype none
module shs_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire shs_pkg::job_t q_job,
  input  wire logic signed [16:0] pose_x,
  input  wire logic signed [16:0] pose_y,
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [15:0] m_tdata,
  output logic busy
);
  import shs_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CORDIC = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_ACC = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  job_t job;
  logic signed [17:0] cx, cy;
  logic signed [16:0] cz;
  logic [3:0] step;
  logic signed [40:0] prod_x, prod_y;
  logic signed [41:0] acc_x, acc_y;
  logic signed [18:0] px, py;
  logic [7:0] left, right, top, bottom, cur_col, cur_row;
  logic signed [19:0] sum;
  logic [15:0] hits;
  logic [15:0] grid [STORE_SIDE*STORE_SIDE];
  logic [15:0] rd_data;
  logic signed [17:0] c_val, s_val;
  logic signed [17:0] dx, dy;
  logic on_grid;

  assign q_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);
  assign dx = cy >>> step;
  assign dy = cx >>> step;

  always_comb begin
    unique case (job.angle[15:14])
      2'd0: begin c_val = cx; s_val = cy; end
      2'd1: begin c_val = -cy; s_val = cx; end
      2'd2: begin c_val = -cx; s_val = -cy; end
      default: begin c_val = cy; s_val = -cx; end
    endcase
  end

  assign on_grid = (px >= 0) && (px < 19'(GRID_COLS)) && (py >= 0) && (py < 19'(GRID_ROWS));

  // neighborhood bounds, clipped to the grid; px and py hold through the reads
  always_comb begin
    left = (px > 0) ? 8'(px - 19'sd1) : 8'd0;
    right = (px < 19'(GRID_COLS - 1)) ? 8'(px + 19'sd1) : 8'(GRID_COLS - 1);
    top = (py > 0) ? 8'(py - 19'sd1) : 8'd0;
    bottom = (py < 19'(GRID_ROWS - 1)) ? 8'(py + 19'sd1) : 8'(GRID_ROWS - 1);
  end

  function automatic logic signed [18:0] rnd(input logic signed [41:0] v);
    logic [41:0] m;
    logic [41:0] r;
    m = v[41] ? 42'(-v) : 42'(v);
    r = (m + 42'(1 << 22)) >> 23;
    rnd = v[41] ? -19'(r) : 19'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && !q_job.is_obs)
      grid[{q_job.row, q_job.col}] <= q_job.value;
    rd_data <= grid[{cur_row, cur_col}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      hits <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid && q_ready && q_job.is_obs) begin
          job <= q_job;
          cx <= CORDIC_START;
          cy <= '0;
          cz <= {3'd0, q_job.angle[13:0]};
          step <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!cz[16]) begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - atan_unit(step);
          end else begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + atan_unit(step);
          end
          step <= step + 4'd1;
          if (step == 4'(CORDIC_STEPS - 1)) state <= S_MUL;
        end
        S_MUL: begin
          prod_x <= $signed({1'b0, job.range}) * c_val;
          prod_y <= $signed({1'b0, job.range}) * s_val;
          state <= S_ROUND;
        end
        S_ROUND: begin
          acc_x <= {{10{pose_x[16]}}, pose_x, 15'd0} + 42'(prod_x);
          acc_y <= {{10{pose_y[16]}}, pose_y, 15'd0} + 42'(prod_y);
          state <= S_ACC;
          step <= '0;
        end
        S_ACC: begin
          if (step == 4'd0) begin
            px <= rnd(acc_x);
            py <= rnd(acc_y);
            step <= 4'd1;
          end else begin
            if (on_grid) begin
              cur_col <= left; cur_row <= top;
              sum <= '0;
              step <= '0;
              state <= S_READ;
            end else state <= S_DONE;
          end
        end
        S_READ: begin
          // one cell per cycle; data for previous address arrives now
          if (step != 4'd0) sum <= sum + 20'($signed(rd_data));
          if (step == 4'd15) begin
            state <= S_DONE;
            if ((sum + 20'($signed(rd_data))) > 0 && hits != 16'hFFFF)
              hits <= hits + 16'd1;
          end else if (cur_col != right) begin
            cur_col <= cur_col + 8'd1; step <= 4'd1;
          end else if (cur_row != bottom) begin
            cur_col <= left; cur_row <= cur_row + 8'd1; step <= 4'd1;
          end else step <= 4'd15;
        end
        S_DONE: begin
          if (!job.last) begin
            state <= S_IDLE;
          end else if (!m_tvalid) begin
            // hold here while the previous count is still waiting
            m_tvalid <= 1'b1;
            m_tdata <= hits;
            hits <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/scan_hit_scorer.sv
`default_nettype none
// Scan hit scorer. Map writes (tuser 0) load grid cells. An observation
// (tuser 1) holds the back end while it is taken, runs 16 CORDIC
// iterations, a multiply and a pose add, is rounded and range checked,
// reads its 3x3 neighborhood from the grid memory one cell at a time
// (fewer cells where it is clipped at the grid edge, none for an off-grid
// point), adds the last read data to the sum and ends in a done state. tlast on an
// observation emits the hit count on m_tdata; while that count waits, only
// the next closing observation stalls. A four-entry queue decouples the
// input from the back end. The grid is not cleared at reset; read only
// cells already written.
module scan_hit_scorer (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [63:0] s_tdata, // col, row, value, range, bearing
  input  wire logic s_tuser,        // req_type
  input  wire logic s_tlast,        // last_obs
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [15:0] m_tdata,      // hit_count
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [16:0] cfg_data
);
  import shs_pkg::*;
  logic signed [16:0] pose_x, pose_y;
  logic [15:0] heading;
  logic q_valid, q_ready, busy;
  job_t q_job;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0; pose_y <= '0; heading <= '0;
    end else if (cfg_valid) begin
      priority case (cfg_index)
        REG_POSE_X: pose_x <= cfg_data;
        REG_POSE_Y: pose_y <= cfg_data;
        REG_HEADING: heading <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  shs_front u_front (.clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .heading, .q_valid, .q_ready, .q_job);
  shs_back u_back (.clk, .rst, .q_valid, .q_ready, .q_job, .pose_x, .pose_y,
    .m_tvalid, .m_tready, .m_tdata, .busy);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_ready) else $error("queue popped while busy");
endmodule
`default_nettype wire
